// ===== src/ffbp_pkg.sv =====
// Shared types and constants for the first-fit bin packer.
// No dependencies; compiled before every other file of the block.
package ffbp_pkg;

    localparam int ITEM_SIZE_W   = 16;
    localparam int BIN_INDEX_W   = 6;
    localparam int BINS_USED_W   = 7;
    localparam int CAP_W         = 16;
    localparam int DEF_MAX_BINS  = 64;
    localparam int DEF_SIZE_BITS = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // register map
    localparam logic [APB_ADDR_W-1:0] ADDR_BIN_CAPACITY = 2'd0;

    // control bits that travel with an item along the cell row
    typedef struct packed {
        logic valid;   // a transaction occupies this stage
        logic placed;  // some bin has already taken it
        logic opened;  // it opened a new bin
        logic over;    // larger than the bin capacity
    } ffbp_flags_t;

endpackage

// ===== src/ffbp_if.sv =====
// Handshake channels of the bin packer: item input and placement result.
// Depends on ffbp_pkg for the field widths.
interface ffbp_item_if import ffbp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ITEM_SIZE_W-1:0] item_size;
    logic                   start_new;

    modport source (output valid, output item_size, output start_new, input ready);
    modport sink   (input valid, input item_size, input start_new, output ready);
endinterface

interface ffbp_result_if import ffbp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [BINS_USED_W-1:0] bins_used;
    logic                   oversize;
    logic                   table_full;

    modport source (output valid, output bin_index, output bins_used, output oversize,
                    output table_full, input ready);
    modport sink   (input valid, input bin_index, input bins_used, input oversize,
                    input table_full, output ready);
endinterface

// ===== src/ffbp_cell.sv =====
// One bin of the packer: open flag, residual capacity and one stage of the
// item row. Depends on ffbp_pkg.
module ffbp_cell import ffbp_pkg::*; #(
    parameter int SIZE_BITS = DEF_SIZE_BITS,
    parameter int IDX_W     = 6,
    parameter int CELL_IDX  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 adv,
    input  logic [SIZE_BITS-1:0] cap,
    input  ffbp_flags_t          flags_in,
    input  logic [SIZE_BITS-1:0] size_in,
    input  logic [IDX_W-1:0]     idx_in,
    output ffbp_flags_t          flags_out,
    output logic [SIZE_BITS-1:0] size_out,
    output logic [IDX_W-1:0]     idx_out
);

    logic                 open_reg;
    logic [SIZE_BITS-1:0] resid_reg;
    ffbp_flags_t          flags_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [IDX_W-1:0]     idx_reg;

    logic fit;
    logic take_new;

    // open bins are contiguous, so the first closed cell is the next free bin
    assign fit      = flags_in.valid && !flags_in.placed && !flags_in.over && open_reg
                      && (resid_reg >= size_in);
    assign take_new = flags_in.valid && !flags_in.placed && !open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                open_reg <= 1'b0;
            end
            else if (adv && take_new)
            begin
                open_reg <= 1'b1;
            end
            if (adv)
            begin
                flags_reg.valid  <= flags_in.valid;
                flags_reg.placed <= flags_in.placed | fit | take_new;
                flags_reg.opened <= flags_in.opened | take_new;
                flags_reg.over   <= flags_in.over;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (fit)
            begin
                resid_reg <= resid_reg - size_in;
            end
            else if (take_new)
            begin
                resid_reg <= flags_in.over ? '0 : cap - size_in;
            end
            size_reg <= size_in;
            idx_reg  <= (fit || take_new) ? IDX_W'(CELL_IDX) : idx_in;
        end
    end

    assign flags_out = flags_reg;
    assign size_out  = size_reg;
    assign idx_out   = idx_reg;

endmodule

// ===== src/first_fit_bin_packer.sv =====
// First-fit bin packer: one transaction at a time walks a row of MAX_BINS cells,
// one cell per cycle. The result is registered after the last cell; the next item
// is accepted only once the current one has left the row.
// A waiting result stalls the row only at its end.
// Reset: all bins closed, bin count zero, bin_capacity = 65535.
// Depends on ffbp_pkg, ffbp_if and ffbp_cell.
module first_fit_bin_packer import ffbp_pkg::*; #(
    parameter int MAX_BINS  = DEF_MAX_BINS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ffbp_item_if.sink             items,
    ffbp_result_if.source         results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    // configuration
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BIN_CAPACITY);
    assign prdata = (paddr == ADDR_BIN_CAPACITY) ? APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // operand widths follow SIZE_BITS
    logic [SIZE_BITS+ITEM_SIZE_W-1:0] size_wide;
    logic [SIZE_BITS+CAP_W-1:0]       cap_wide;
    logic [SIZE_BITS-1:0]             size_in;
    logic [SIZE_BITS-1:0]             cap;

    assign size_wide = {{SIZE_BITS{1'b0}}, items.item_size};
    assign cap_wide  = {{SIZE_BITS{1'b0}}, cap_reg};
    assign size_in   = size_wide[SIZE_BITS-1:0];
    assign cap       = cap_wide[SIZE_BITS-1:0];

    // control
    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    logic             adv;
    logic             exit_tok;

    ffbp_flags_t          flags_c [MAX_BINS+1];
    logic [SIZE_BITS-1:0] size_c  [MAX_BINS+1];
    logic [IDX_W-1:0]     idx_c   [MAX_BINS+1];

    ffbp_flags_t          tok_flags_reg;
    logic [SIZE_BITS-1:0] tok_size_reg;

    assign items.ready = !busy_reg;
    assign accept      = items.valid && !busy_reg;
    // only the transaction leaving the row can meet a full result register
    assign adv         = !(flags_c[MAX_BINS].valid && results.valid && !results.ready);
    assign exit_tok    = adv && flags_c[MAX_BINS].valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_flags_reg <= '0;
        end
        else if (accept)
        begin
            tok_flags_reg.valid  <= 1'b1;
            tok_flags_reg.placed <= 1'b0;
            tok_flags_reg.opened <= 1'b0;
            tok_flags_reg.over   <= size_in > cap;
        end
        else if (adv)
        begin
            tok_flags_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_size_reg <= size_in;
        end
    end

    assign flags_c[0] = tok_flags_reg;
    assign size_c[0]  = tok_size_reg;
    assign idx_c[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BINS; g++)
        begin : g_cell
            ffbp_cell #(
                .SIZE_BITS (SIZE_BITS),
                .IDX_W     (IDX_W),
                .CELL_IDX  (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .clear     (accept && items.start_new),
                .adv       (adv),
                .cap       (cap),
                .flags_in  (flags_c[g]),
                .size_in   (size_c[g]),
                .idx_in    (idx_c[g]),
                .flags_out (flags_c[g+1]),
                .size_out  (size_c[g+1]),
                .idx_out   (idx_c[g+1])
            );
        end
    endgenerate

    // result assembly
    logic [CNT_W-1:0]             count_after;
    logic [CNT_W+BINS_USED_W-1:0] used_wide;
    logic [IDX_W+BIN_INDEX_W-1:0] idx_wide;

    assign count_after = flags_c[MAX_BINS].opened ? count_reg + CNT_W'(1) : count_reg;
    assign used_wide   = {{BINS_USED_W{1'b0}}, count_after};
    assign idx_wide    = {{BIN_INDEX_W{1'b0}}, idx_c[MAX_BINS]};

    logic                   res_valid_reg;
    logic [BIN_INDEX_W-1:0] res_index_reg;
    logic [BINS_USED_W-1:0] res_used_reg;
    logic                   res_over_reg;
    logic                   res_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                if (items.start_new)
                begin
                    count_reg <= '0;
                end
            end
            else if (exit_tok)
            begin
                busy_reg  <= 1'b0;
                count_reg <= count_after;
            end
            if (exit_tok)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exit_tok)
        begin
            res_index_reg <= idx_wide[BIN_INDEX_W-1:0];
            res_used_reg  <= used_wide[BINS_USED_W-1:0];
            res_over_reg  <= flags_c[MAX_BINS].over;
            res_full_reg  <= !flags_c[MAX_BINS].placed;
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.bin_index  = res_index_reg;
    assign results.bins_used  = res_used_reg;
    assign results.oversize   = res_over_reg;
    assign results.table_full = res_full_reg;

    // checks
    logic [MAX_BINS:0] row_valid;

    always_comb
    begin
        for (int i = 0; i <= MAX_BINS; i++)
        begin
            row_valid[i] = flags_c[i].valid;
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(row_valid))
        else $error("more than one transaction in the cell row");

    a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> row_valid == '0)
        else $error("cell row holds a transaction while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BINS))
        else $error("bin count above table size");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok && !flags_c[MAX_BINS].placed |-> count_reg == CNT_W'(MAX_BINS))
        else $error("transaction dropped with free bins left");

    a_exit_frees: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok |=> results.valid && !busy_reg)
        else $error("result not presented after leaving the row");

endmodule

// ===== bench/first_fit_bin_packer_tb.sv =====
// Self-checking bench for first_fit_bin_packer: directed and random item streams
// against an in-bench first-fit placement model, checked transaction by transaction.
// Depends on ffbp_pkg, the ffbp_item_if / ffbp_result_if interfaces and first_fit_bin_packer.
`timescale 1ns / 1ps

module first_fit_bin_packer_tb;
    import ffbp_pkg::*;

    localparam int          BINS        = DEF_MAX_BINS;
    localparam int          ITEMS_PHASE = 215;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [ITEM_SIZE_W-1:0] size;
        logic                   fresh;
    } item_t;

    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [BINS_USED_W-1:0] bins_used;
        logic                   oversize;
        logic                   table_full;
    } placement_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ffbp_item_if   item_ch();
    ffbp_result_if result_ch();

    first_fit_bin_packer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // placement model state
    logic [CAP_W-1:0] residual [BINS];
    int unsigned      open_bins = 0;
    logic [CAP_W-1:0] bin_cap   = CAP_RESET;

    item_t       pending_items [$];
    placement_t  placements    [$];
    bit          idle_on = 1'b0;
    int unsigned send_gap;
    int unsigned hold;
    int unsigned errors = 0;
    int unsigned cycles = 0;

    function automatic placement_t place_item(logic [ITEM_SIZE_W-1:0] size, logic fresh);
        placement_t r;
        logic       over;
        bit         found;
        int         j;
        r     = '0;
        found = 1'b0;
        over  = size > bin_cap;
        if (fresh)
            open_bins = 0;
        if (!over)
            for (j = 0; j < open_bins; j++)
                if (!found && residual[j] >= size)
                begin
                    residual[j] = residual[j] - size;
                    r.bin_index = j;
                    r.bins_used = open_bins;
                    found       = 1'b1;
                end
        if (!found)
        begin
            r.oversize = over;
            if (open_bins >= BINS)
            begin
                // nowhere to go: dropped, count unchanged
                r.bin_index  = '0;
                r.bins_used  = open_bins;
                r.table_full = 1'b1;
            end
            else
            begin
                residual[open_bins] = over ? '0 : bin_cap - size;
                r.bin_index         = open_bins;
                open_bins++;
                r.bins_used         = open_bins;
            end
        end
        return r;
    endfunction

    function automatic logic [ITEM_SIZE_W-1:0] pick_size(bit one_per_bin, int unsigned cap);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10 && cap < 65535)
            return $urandom_range(cap + 1, 65535);
        if (one_per_bin)
            return $urandom_range(cap / 2 + 1, cap);
        if (roll < 25)
            return $urandom_range(0, 65535);
        if (roll < 30)
            return '0;
        if (roll < 40)
            return cap;
        if (roll < 70)
            return $urandom_range(0, cap / 8);
        return $urandom_range(cap / 4, cap);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // item driver; the gap only runs down while the block could take an item
    always @(posedge clk or negedge rst_n)
    begin
        item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid     <= 1'b0;
            item_ch.item_size <= '0;
            item_ch.start_new <= 1'b0;
            send_gap          <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                placements.push_back(place_item(item_ch.item_size, item_ch.start_new));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    item_ch.valid <= 1'b0;
                    if (item_ch.ready || placements.size() == 0)
                        send_gap <= send_gap - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    nxt               = pending_items.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.item_size <= nxt.size;
                    item_ch.start_new <= nxt.fresh;
                    send_gap          <= idle_on ? $urandom_range(0, 3) : 0;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor; stalls are counted against a waiting result
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (placements.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual bin %0d used %0d",
                             $time, result_ch.bin_index, result_ch.bins_used);
                    errors++;
                end
                else
                begin
                    want = placements.pop_front();
                    check_field("bin_index", want.bin_index, result_ch.bin_index);
                    check_field("bins_used", want.bins_used, result_ch.bins_used);
                    check_field("oversize", want.oversize, result_ch.oversize);
                    check_field("table_full", want.table_full, result_ch.table_full);
                end
                hold = idle_on ? $urandom_range(0, 3) : 0;
                result_ch.ready <= (hold == 0);
            end
            else if (result_ch.valid && hold != 0)
            begin
                hold = hold - 1;
                result_ch.ready <= (hold == 0);
            end
            else if (hold == 0)
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_item(logic fresh, logic [ITEM_SIZE_W-1:0] size);
        item_t it;
        it.size  = size;
        it.fresh = fresh;
        pending_items.push_back(it);
    endtask

    // runs of items, each opening a new instance; one-per-bin runs can fill the table
    task automatic queue_random(int unsigned count);
        int unsigned left;
        int unsigned run;
        int unsigned k;
        bit          one_per_bin;
        left = count;
        while (left != 0)
        begin
            one_per_bin = ($urandom_range(0, 99) < 40);
            run = one_per_bin ? $urandom_range(64, 100) : $urandom_range(10, 150);
            if (run > left)
                run = left;
            for (k = 0; k < run; k++)
                push_item((k == 0) || ($urandom_range(0, 99) < 3), pick_size(one_per_bin, bin_cap));
            left -= run;
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || item_ch.valid || placements.size() != 0)
            @(posedge clk);
        repeat (BINS + 1) @(posedge clk);
    endtask

    initial
    begin
        int unsigned caps [6];
        int          p;
        item_ch.valid     = 1'b0;
        item_ch.item_size = '0;
        item_ch.start_new = 1'b0;
        result_ch.ready   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        caps = '{65535, 1, 100, $urandom_range(2, 65534), 65535, $urandom_range(1, 255)};
        for (p = 0; p < 6; p++)
        begin
            apb_write(ADDR_BIN_CAPACITY, caps[p]);
            bin_cap = caps[p];
            idle_on = (p % 3 != 2);
            if (p == 0)
            begin
                push_item(1'b1, 16'h0000);   // empty table, zero size opens a bin with its full capacity left
                push_item(1'b0, 16'hFFFF);   // exactly fills bin 0
                push_item(1'b0, 16'h0000);   // zero size still fits a full bin
                push_item(1'b0, 16'h0001);
                push_item(1'b0, 16'h8000);
                push_item(1'b0, 16'h7FFF);
                push_item(1'b1, 16'hFFFF);
                push_item(1'b0, 16'hFFFF);
            end
            else if (p == 1)
            begin
                // old bins keep their room after the capacity drops
                push_item(1'b0, 16'h0001);
                push_item(1'b0, 16'h0002);
                push_item(1'b1, 16'h0001);
                push_item(1'b0, 16'h0002);   // oversize opens a new bin with no room left
                push_item(1'b0, 16'hFFFF);
                push_item(1'b0, 16'h0000);
                push_item(1'b0, 16'h0001);
            end
            queue_random(ITEMS_PHASE);
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
